### src/assert_macros.svh
// Assertion shorthands; each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LSI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LSI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lsi_pkg.sv
package lsi_pkg;

  localparam int DATA_W        = 32;
  localparam int KIDX_W        = 6;
  localparam int KCNT_W        = 7;
  localparam int KCNT_RST      = 2;
  localparam int MAX_KNOTS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;
  // one shift-add step per bit of the 33-bit distance magnitude
  localparam int MUL_STEPS     = DATA_W + 1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_PREP,
    ST_DIV,
    ST_LD_WR,
    ST_Q_SCAN,
    ST_Q_RD,
    ST_Q_PREP,
    ST_MUL,
    ST_Q_SH,
    ST_Q_FIN
  } lsi_state_t;

endpackage

### src/lsi_in_if.sv
interface lsi_in_if import lsi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [KIDX_W-1:0] knot_index;
  logic [DATA_W-1:0] x_value;
  logic [DATA_W-1:0] y_value;

  modport source (output valid, req_type, knot_index, x_value, y_value, input ready);
  modport sink   (input valid, req_type, knot_index, x_value, y_value, output ready);
endinterface

### src/lsi_out_if.sv
interface lsi_out_if import lsi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result_value;
  logic              outside_span;
  logic              saturated;

  modport source (output valid, result_value, outside_span, saturated, input ready);
  modport sink   (input valid, result_value, outside_span, saturated, output ready);
endinterface

### src/linear_spline_interpolator.sv
// Piecewise linear interpolator over a knot table in signed fixed point
// (FRAC_BITS fraction bits). A load item writes knot x/y at an index and, for
// index 1 and up, computes the slope of the segment ending there with a
// restoring divider, one quotient bit per cycle: the previous knot is read,
// the divider is set up and run, and the slope is written; a gap in x that is
// not positive skips the divider and writes a zero slope. A query scans the
// knot x table one entry per cycle until the first knot above the query point
// or the last knot, then forms y + slope * (query - x) with a shift-add
// multiplier, one bit per cycle over 33 bits. Divider and multiplier share one
// 33-bit add/subtract unit, so one item is in work at a time; a finished
// result waits in the output register while the next item is taken.
// Queries below the first knot or beyond the last one extrapolate the end
// segment and set outside_span; results clamp to the 32-bit range and set
// saturated. knot_count (2..MAX_KNOTS effective) is written on cfg_we.
`include "assert_macros.svh"

module linear_spline_interpolator import lsi_pkg::*; #(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  lsi_in_if.sink            in_chan,
  lsi_out_if.source         out_chan,
  input  logic              cfg_we,
  input  logic [KCNT_W-1:0] cfg_wdata
);

  localparam int IDX_W   = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int CNT_W   = (IDX_W + 1 > KCNT_W) ? IDX_W + 1 : KCNT_W;
  localparam int NUM_W   = DATA_W + 1 + FRAC_BITS;
  localparam int ITER_W  = $clog2(NUM_W);
  localparam int PROD_W  = 2 * DATA_W + 1;
  localparam int PM_W    = 2 * DATA_W;
  localparam int SH_W    = PM_W - FRAC_BITS;
  localparam int RES_W   = SH_W + 2;
  localparam int KTAB_N  = 1 << KIDX_W;

  lsi_state_t state_r, state_nxt;

  logic [KCNT_W-1:0] kcnt_r, kcnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [DATA_W-1:0] v_r, v_nxt;
  logic [DATA_W-1:0] yv_r, yv_nxt;
  logic [IDX_W-1:0]  kidx_r, kidx_nxt;
  logic [IDX_W-1:0]  last_r, last_nxt;
  logic [IDX_W-1:0]  scan_r, scan_nxt;
  logic [IDX_W-1:0]  cmp_i_r, cmp_i_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  seg_r, seg_nxt;
  logic              outside_r, outside_nxt;
  logic              neg_r, neg_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dvsr_r, dvsr_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic [SH_W-1:0]   sh_r, sh_nxt;
  logic [DATA_W-1:0] out_res_r, out_res_nxt;
  logic              out_outside_r, out_outside_nxt;
  logic              out_sat_r, out_sat_nxt;

  // knot table and segment slopes
  logic [DATA_W-1:0] knot_x_mem    [MAX_KNOTS];
  logic [DATA_W-1:0] knot_y_mem    [MAX_KNOTS];
  logic [DATA_W-1:0] seg_slope_mem [MAX_KNOTS];
  logic [DATA_W-1:0] rdx_r, rdy_r, rds_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              xy_we;
  logic [IDX_W-1:0]  xy_addr;
  logic              slope_we;
  logic [DATA_W-1:0] slope_val;

  // shared add/subtract unit
  logic [DATA_W:0]   au_a, au_b;
  logic              au_sub;
  logic [DATA_W+1:0] au_res;

  logic              in_acc;
  logic [IDX_W-1:0]  wrap_tab [KTAB_N];

  // knot index wraps modulo the table depth
  for (genvar g = 0; g < KTAB_N; g++) begin : g_wrap
    assign wrap_tab[g] = IDX_W'(g % MAX_KNOTS);
  end

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign xy_addr       = wrap_tab[in_chan.knot_index];

  assign au_res = au_sub ? ({1'b0, au_a} - {1'b0, au_b}) : ({1'b0, au_a} + {1'b0, au_b});

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_value = out_res_r;
  assign out_chan.outside_span = out_outside_r;
  assign out_chan.saturated    = out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    logic [CNT_W-1:0]  kc_ext;
    logic [CNT_W-1:0]  n_eff;
    logic [DATA_W:0]   dx_w, dy_w, d_w;
    logic [DATA_W:0]   mag_dy, mag_d;
    logic [DATA_W-1:0] mag_s;
    logic [DATA_W:0]   div_a;
    logic [DATA_W:0]   mul_sum;
    logic              big_q;
    logic [DATA_W-1:0] q_cl;
    logic [PM_W-1:0]   pm, pm_adj;
    logic [RES_W-1:0]  y_ext, sh_ext, res_w;
    logic              ovf;

    state_nxt       = state_r;
    kcnt_nxt        = kcnt_r;
    v_nxt           = v_r;
    yv_nxt          = yv_r;
    kidx_nxt        = kidx_r;
    last_nxt        = last_r;
    scan_nxt        = scan_r;
    cmp_i_nxt       = cmp_i_r;
    cmp_vld_nxt     = cmp_vld_r;
    seg_nxt         = seg_r;
    outside_nxt     = outside_r;
    neg_nxt         = neg_r;
    num_nxt         = num_r;
    rem_nxt         = rem_r;
    dvsr_nxt        = dvsr_r;
    prod_nxt        = prod_r;
    cnt_nxt         = cnt_r;
    sh_nxt          = sh_r;
    out_res_nxt     = out_res_r;
    out_outside_nxt = out_outside_r;
    out_sat_nxt     = out_sat_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    rd_addr         = seg_r;
    xy_we           = 1'b0;
    slope_we        = 1'b0;
    slope_val       = '0;
    au_a            = '0;
    au_b            = '0;
    au_sub          = 1'b0;

    kc_ext = CNT_W'(kcnt_r);
    if (kc_ext < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (kc_ext > CNT_W'(MAX_KNOTS)) begin
      n_eff = CNT_W'(MAX_KNOTS);
    end else begin
      n_eff = kc_ext;
    end

    dx_w   = {v_r[DATA_W-1], v_r} - {rdx_r[DATA_W-1], rdx_r};
    dy_w   = {yv_r[DATA_W-1], yv_r} - {rdy_r[DATA_W-1], rdy_r};
    d_w    = dx_w;
    mag_dy = dy_w[DATA_W] ? (~dy_w + 1'b1) : dy_w;
    mag_d  = d_w[DATA_W] ? (~d_w + 1'b1) : d_w;
    mag_s  = rds_r[DATA_W-1] ? (~rds_r + 1'b1) : rds_r;
    div_a  = {rem_r, num_r[NUM_W-1]};
    mul_sum = {1'b0, prod_r[PROD_W-1:DATA_W+1]};

    big_q = (|num_r[NUM_W-1:DATA_W]) || (num_r[DATA_W-1] && (|num_r[DATA_W-2:0]));
    q_cl  = big_q ? {1'b1, {(DATA_W-1){1'b0}}} : num_r[DATA_W-1:0];

    pm     = prod_r[PM_W-1:0];
    pm_adj = pm + ((PM_W'(1) << FRAC_BITS) - PM_W'(1));

    y_ext  = {{(RES_W-DATA_W){yv_r[DATA_W-1]}}, yv_r};
    sh_ext = {2'b00, sh_r};
    res_w  = neg_r ? (y_ext - sh_ext) : (y_ext + sh_ext);
    ovf    = !((&res_w[RES_W-1:DATA_W-1]) || !(|res_w[RES_W-1:DATA_W-1]));

    if (cfg_we) begin
      kcnt_nxt = cfg_wdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          v_nxt = in_chan.x_value;
          if (in_chan.req_type == REQ_LOAD) begin
            xy_we    = 1'b1;
            yv_nxt   = in_chan.y_value;
            kidx_nxt = xy_addr;
            if (xy_addr != '0) begin
              state_nxt = ST_LD_RD;
            end
          end else begin
            last_nxt    = IDX_W'(n_eff - CNT_W'(1));
            scan_nxt    = '0;
            cmp_vld_nxt = 1'b0;
            state_nxt   = ST_Q_SCAN;
          end
        end
      end

      ST_LD_RD: begin
        rd_addr   = kidx_r - 1'b1;
        state_nxt = ST_LD_PREP;
      end

      ST_LD_PREP: begin
        rem_nxt  = '0;
        dvsr_nxt = dx_w[DATA_W-1:0];
        neg_nxt  = dy_w[DATA_W];
        cnt_nxt  = ITER_W'(NUM_W - 1);
        // a non-positive gap leaves a zero quotient
        if (dx_w[DATA_W] || (dx_w == '0)) begin
          num_nxt   = '0;
          state_nxt = ST_LD_WR;
        end else begin
          num_nxt   = {mag_dy, {FRAC_BITS{1'b0}}};
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        au_a    = div_a;
        au_b    = {1'b0, dvsr_r};
        au_sub  = 1'b1;
        rem_nxt = au_res[DATA_W+1] ? div_a[DATA_W-1:0] : au_res[DATA_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], !au_res[DATA_W+1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_LD_WR;
        end
      end

      ST_LD_WR: begin
        slope_we = 1'b1;
        if (neg_r) begin
          slope_val = ~q_cl + 1'b1;
        end else if (q_cl[DATA_W-1]) begin
          slope_val = {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
          slope_val = q_cl;
        end
        state_nxt = ST_IDLE;
      end

      ST_Q_SCAN: begin
        // compare uses the registered read of the previous scan address
        rd_addr     = scan_r;
        scan_nxt    = (scan_r == last_r) ? scan_r : scan_r + 1'b1;
        cmp_vld_nxt = 1'b1;
        cmp_i_nxt   = scan_r;
        if (cmp_vld_r) begin
          if ($signed(rdx_r) > $signed(v_r)) begin
            state_nxt = ST_Q_RD;
            if (cmp_i_r == '0) begin
              seg_nxt     = '0;
              outside_nxt = 1'b1;
            end else begin
              seg_nxt     = cmp_i_r - 1'b1;
              outside_nxt = 1'b0;
            end
          end else if (cmp_i_r == last_r) begin
            state_nxt   = ST_Q_RD;
            seg_nxt     = last_r - 1'b1;
            outside_nxt = (rdx_r != v_r);
          end
        end
      end

      ST_Q_RD: begin
        rd_addr   = seg_r;
        state_nxt = ST_Q_PREP;
      end

      ST_Q_PREP: begin
        yv_nxt    = rdy_r;
        neg_nxt   = rds_r[DATA_W-1] ^ d_w[DATA_W];
        dvsr_nxt  = mag_s;
        prod_nxt  = {{DATA_W{1'b0}}, mag_d};
        cnt_nxt   = ITER_W'(MUL_STEPS - 1);
        state_nxt = ST_MUL;
      end

      ST_MUL: begin
        au_a     = {1'b0, prod_r[PROD_W-1:DATA_W+1]};
        au_b     = {1'b0, dvsr_r};
        au_sub   = 1'b0;
        if (prod_r[0]) begin
          mul_sum = au_res[DATA_W:0];
        end
        prod_nxt = {mul_sum, prod_r[DATA_W:1]};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_Q_SH;
        end
      end

      ST_Q_SH: begin
        // negative product rounds toward minus infinity
        neg_nxt   = neg_r && (|pm);
        sh_nxt    = (neg_r && (|pm)) ? pm_adj[PM_W-1:FRAC_BITS] : pm[PM_W-1:FRAC_BITS];
        state_nxt = ST_Q_FIN;
      end

      ST_Q_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt   = 1'b1;
          out_outside_nxt = outside_r;
          out_sat_nxt     = ovf;
          if (ovf) begin
            out_res_nxt = res_w[RES_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}};
          end else begin
            out_res_nxt = res_w[DATA_W-1:0];
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kcnt_r      <= KCNT_W'(KCNT_RST);
      out_valid_r <= 1'b0;
    end else begin
      kcnt_r      <= kcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r           <= v_nxt;
    yv_r          <= yv_nxt;
    kidx_r        <= kidx_nxt;
    last_r        <= last_nxt;
    scan_r        <= scan_nxt;
    cmp_i_r       <= cmp_i_nxt;
    cmp_vld_r     <= cmp_vld_nxt;
    seg_r         <= seg_nxt;
    outside_r     <= outside_nxt;
    neg_r         <= neg_nxt;
    num_r         <= num_nxt;
    rem_r         <= rem_nxt;
    dvsr_r        <= dvsr_nxt;
    prod_r        <= prod_nxt;
    cnt_r         <= cnt_nxt;
    sh_r          <= sh_nxt;
    out_res_r     <= out_res_nxt;
    out_outside_r <= out_outside_nxt;
    out_sat_r     <= out_sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (xy_we) begin
      knot_x_mem[xy_addr] <= in_chan.x_value;
      knot_y_mem[xy_addr] <= in_chan.y_value;
    end
    if (slope_we) begin
      seg_slope_mem[kidx_r - 1'b1] <= slope_val;
    end
    rdx_r <= knot_x_mem[rd_addr];
    rdy_r <= knot_y_mem[rd_addr];
    rds_r <= seg_slope_mem[rd_addr];
  end

  `LSI_ASSERT_IMP(a_scan_in_range, (state_r == ST_Q_SCAN) && cmp_vld_r, cmp_i_r <= last_r, "scan passed last knot")
  `LSI_ASSERT_IMP(a_seg_in_range, state_r == ST_Q_RD, seg_r < last_r, "segment beyond last knot")
  `LSI_ASSERT_IMP(a_result_from_fin, $rose(out_valid_r), $past(state_r) == ST_Q_FIN, "result not from final step")
  `LSI_ASSERT_NXT(a_load_no_query, in_acc && (in_chan.req_type == REQ_LOAD), (state_r == ST_IDLE) || (state_r == ST_LD_RD), "load entered query path")

endmodule
